// File: rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU cache package
// Shared constants, state type and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CAP_W = 5;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CNT_W = 32;
  localparam int STAMP_W = 48;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;
  localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_OUT
  } lfu_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the input beat, clear scan results
    logic scan_step;  // examine the entry at the scan index
    logic apply;      // perform the update chosen after the scan
  } lfu_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_last;  // scan index is at the final entry
  } lfu_status_t;

endpackage

// File: rtl/lfu_datapath.sv
// ----------------------------------------------------------------------------
// LFU cache datapath
// Entry table, sequential scan for key match, victim and free slot, and
// the update applied once the scan has finished.
// ----------------------------------------------------------------------------
module lfu_datapath import lfu_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  lfu_cmd_t            cmd,
  output lfu_status_t         status,
  input  logic [CAP_W-1:0]    capacity,
  input  logic                in_action,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [VAL_W-1:0]    in_value,
  output logic                res_hit,
  output logic [VAL_W-1:0]    res_value
);

  // Entry table; only valid entries are ever read.
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [KEY_W-1:0]   key_mem   [TABLE_ENTRIES];
  logic [VAL_W-1:0]   val_mem   [TABLE_ENTRIES];
  logic [CNT_W-1:0]   cnt_mem   [TABLE_ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [TABLE_ENTRIES];

  logic [STAMP_W-1:0] stamp_r;
  logic [CAP_W-1:0]   occ_r;

  // Captured beat and scan results.
  logic               act_r;
  logic [KEY_W-1:0]   key_r;
  logic [VAL_W-1:0]   val_r;
  logic [IDX_W-1:0]   idx_r;
  logic               match_found_r, victim_found_r, free_found_r;
  logic [IDX_W-1:0]   match_idx_r, victim_idx_r, free_idx_r;
  logic [CNT_W-1:0]   victim_cnt_r;
  logic [STAMP_W-1:0] victim_stamp_r;
  logic               hit_r;
  logic [VAL_W-1:0]   res_r;

  logic [CAP_W-1:0]   eff_cap;
  logic               better;
  logic [STAMP_W-1:0] stamp_nxt;

  assign eff_cap = (capacity < CAP_W'(TABLE_ENTRIES)) ? capacity : CAP_W'(TABLE_ENTRIES);
  assign status.scan_last = (idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign stamp_nxt = stamp_r + STAMP_W'(1);
  assign res_hit = hit_r;
  assign res_value = res_r;

  // Victim ordering: lower count, then older stamp; ties keep the lower index.
  assign better = !victim_found_r || (cnt_mem[idx_r] < victim_cnt_r) ||
                  ((cnt_mem[idx_r] == victim_cnt_r) && (stamp_mem[idx_r] < victim_stamp_r));

  // Scan bookkeeping and captured beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      key_r <= in_key;
      val_r <= in_value;
      idx_r <= '0;
      match_found_r <= 1'b0;
      victim_found_r <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + IDX_W'(1);
      if (valid_r[idx_r]) begin
        if (!match_found_r && key_mem[idx_r] == key_r) begin
          match_found_r <= 1'b1;
          match_idx_r <= idx_r;
        end
        if (better) begin
          victim_found_r <= 1'b1;
          victim_idx_r <= idx_r;
          victim_cnt_r <= cnt_mem[idx_r];
          victim_stamp_r <= stamp_mem[idx_r];
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r <= idx_r;
      end
    end
  end

  // Update of the table once the scan has finished.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      stamp_r <= '0;
      occ_r <= '0;
    end else if (cmd.apply) begin
      if (match_found_r) begin
        stamp_r <= stamp_nxt;
        stamp_mem[match_idx_r] <= stamp_nxt;
        if (cnt_mem[match_idx_r] != COUNT_MAX) begin
          cnt_mem[match_idx_r] <= cnt_mem[match_idx_r] + CNT_W'(1);
        end
        if (act_r == ACT_PUT) begin
          val_mem[match_idx_r] <= val_r;
        end
      end else if (act_r == ACT_PUT && eff_cap != '0) begin
        if (occ_r >= eff_cap) begin
          // Full: the victim slot is reused; occupancy stays put.
          if (victim_found_r) begin
            key_mem[victim_idx_r] <= key_r;
            val_mem[victim_idx_r] <= val_r;
            cnt_mem[victim_idx_r] <= CNT_W'(1);
            stamp_mem[victim_idx_r] <= stamp_nxt;
            stamp_r <= stamp_nxt;
          end
        end else if (free_found_r) begin
          valid_r[free_idx_r] <= 1'b1;
          key_mem[free_idx_r] <= key_r;
          val_mem[free_idx_r] <= val_r;
          cnt_mem[free_idx_r] <= CNT_W'(1);
          stamp_mem[free_idx_r] <= stamp_nxt;
          stamp_r <= stamp_nxt;
          occ_r <= occ_r + CAP_W'(1);
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      hit_r <= (act_r == ACT_GET) && match_found_r;
      if (act_r == ACT_PUT) begin
        res_r <= '0;
      end else if (match_found_r) begin
        res_r <= val_mem[match_idx_r];
      end else begin
        res_r <= MISS_VALUE;
      end
    end
  end

endmodule

// File: rtl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences load, table scan, update and result handshake.
// ----------------------------------------------------------------------------
module lfu_ctrl import lfu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic        out_fire,
  input  lfu_status_t status,
  output lfu_cmd_t    cmd,
  output logic        busy,
  output logic        out_valid
);

  lfu_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.apply = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == ST_IDLE) else $error("load outside idle");
  a_apply_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> out_valid) else $error("result not presented after update");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fire |=> out_valid) else $error("result dropped");

endmodule

// File: rtl/lfu_cache_with_lru_tiebreak.sv
// ----------------------------------------------------------------------------
// LFU cache with LRU tie-break
// Key-value cache, least-frequently-used replacement, oldest entry among
// the lowest count evicted.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// in_      slave      tdata: action[0], key[32:1], value_in[64:33]
// out_     master     tdata: hit[0], value_out[32:1]
// cfg_     slave      cache_capacity[4:0]
//
// A beat runs from one accept to the next, when the result is taken at once,
// through the accepting cycle, the table scan, which examines every entry in
// turn, the update and the presentation of the result.
// The next beat is accepted once the result has been taken.
// Reset is synchronous, active low, and clears all valid bits at once.
// A stalled result holds until out_tready is high.
// ----------------------------------------------------------------------------
module lfu_cache_with_lru_tiebreak import lfu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // action, key, value_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // hit, value_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // cache_capacity
);

  lfu_cmd_t    cmd;
  lfu_status_t status;
  logic        busy, hit;
  logic [VAL_W-1:0] value;
  logic [CAP_W-1:0] cap_r;

  assign in_tready = !busy;
  assign cfg_ready = 1'b1;
  assign out_tdata = {7'd0, value, hit};

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(16);
    end else if (cfg_valid) begin
      cap_r <= cfg_data[CAP_W-1:0];
    end
  end

  lfu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_tvalid && in_tready),
    .out_fire(out_tvalid && out_tready),
    .status(status), .cmd(cmd), .busy(busy), .out_valid(out_tvalid)
  );

  lfu_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .capacity(cap_r),
    .in_action(in_tdata[0]), .in_key(in_tdata[32:1]), .in_value(in_tdata[64:33]),
    .res_hit(hit), .res_value(value)
  );

endmodule
